// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/nops_pkg.sv
// types, constants and the cosine table of the oscillator phase update
package nops_pkg;

    // phase store geometry
    localparam int MAX_OSC = 512;
    localparam int OSC_AW  = $clog2(MAX_OSC);
    localparam int CNT_W   = OSC_AW + 1;

    // item field widths
    localparam int IDX_W   = 9;
    localparam int PH_W    = 16;
    localparam int CNT_REG_W = 10;
    localparam int TDATA_W = 32;

    // op codes carried in tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] CFG_OMEGA      = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_TIME_CONST = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_STEP_DT    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_GAIN_A     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PHASE_LAG  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_OSC_COUNT  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_INV_COUNT  = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_OMEGA      = 16'd2867;
    localparam logic [15:0] RST_TIME_CONST = 16'd256;
    localparam logic [15:0] RST_STEP_DT    = 16'd655;
    localparam logic [15:0] RST_GAIN_A     = 16'd15565;
    localparam logic [15:0] RST_PHASE_LAG  = 16'd2086;
    localparam logic [CNT_REG_W-1:0] RST_OSC_COUNT = 10'd500;
    localparam logic [15:0] RST_INV_COUNT  = 16'd131;

    // arithmetic constants
    localparam logic signed [31:0] KERN_ONE = 32'sd268435456;  // 1.0 in Q28
    localparam logic [31:0] KTURN_Q14 = 32'd170891319;         // 32768/pi in Q14
    localparam int SUM_W = 56;

    // serial multiplier: 64-bit operand times 32-bit operand, modulo 2^64
    localparam int MUL_AW    = 64;
    localparam int MUL_BW    = 32;
    localparam int MUL_DIGIT = 4;
    localparam int MUL_STEPS = MUL_BW / MUL_DIGIT;
    localparam int MUL_CW    = $clog2(MUL_STEPS);

    typedef struct packed {
        logic              valid;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [MUL_AW-1:0] prod;
    } t_mul_rsp;

    // cosine table: one quadrant, angle cut to COS_TABLE_BITS bits
    localparam int COS_TABLE_BITS = 10;
    localparam int QTR_BITS = COS_TABLE_BITS - 2;
    localparam int QTR_N    = 1 << QTR_BITS;

    typedef logic [14:0] t_cos_tab [0:QTR_N];

    // even polynomial for cos over the first quadrant, Q1.14
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        longint   u;
        longint   x;
        longint   y;
        longint   p;
        longint   r;
        for (int k = 0; k <= QTR_N; k++) begin
            u = longint'(k) << (14 - QTR_BITS);
            x = u << 2;
            y = (x * x) >>> 16;
            p = 60;
            p = 1367 - ((p * y) >>> 16);
            p = 16625 - ((p * y) >>> 16);
            p = 80852 - ((p * y) >>> 16);
            if (p < 0) begin
                p = 0;
            end
            r = 65536 - ((p * y) >>> 16);
            if (r < 0) begin
                r = 0;
            end
            tab[k] = 15'((r + 2) >>> 2);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

    // full-turn cosine from the quadrant table
    function automatic logic signed [15:0] cos_lookup(input logic [15:0] angle);
        logic [1:0]          quad;
        logic [QTR_BITS-1:0] frac;
        logic [QTR_BITS:0]   tix;
        logic signed [15:0]  val;
        quad = angle[15:14];
        frac = angle[13:14-QTR_BITS];
        tix  = quad[0] ? ((QTR_BITS+1)'(QTR_N) - {1'b0, frac}) : {1'b0, frac};
        val  = $signed({1'b0, COS_TAB[tix]});
        return (quad[0] ^ quad[1]) ? -val : val;
    endfunction

endpackage

// File: rtl/nops_mul.sv
// serial multiplier, four bits of the second operand per cycle, modulo 2^64
`include "assert_macros.svh"

module nops_mul
    import nops_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [MUL_CW-1:0] r_cnt;
    logic [MUL_AW-1:0] r_acc;
    logic [MUL_AW-1:0] r_a;
    logic [MUL_BW-1:0] r_b;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.valid) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CW'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and add, one digit of b per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= r_acc + r_a * MUL_AW'(r_b[MUL_DIGIT-1:0]);
            r_a   <= r_a << MUL_DIGIT;
            r_b   <= r_b >> MUL_DIGIT;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    // checks
    `ASSERT_NEVER(a_mul_start_busy, i_clk, i_rst_n, i_req.valid && r_busy,
                  "multiplier started while busy")
    `ASSERT_CLK(a_mul_start_runs, i_clk, i_rst_n, i_req.valid |=> r_busy,
                "multiplier did not start")
    `ASSERT_CLK(a_mul_end_done, i_clk, i_rst_n, $fell(r_busy) |-> r_done,
                "multiplier stopped without done")

endmodule

// File: rtl/nonlocal_phase_oscillator_update.sv
// ring of phase oscillators: load a phase or take one coupled euler step
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: op; tdata: index, phase_in
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: index_out, phase_out
//  cfg      | in  | i_cfg_we                      | i_cfg_addr, i_cfg_data
//
//  a load item goes from idle to the done state, then to the output register.
//  an update item makes one phase store read per oscillator through the single
//  read port, for n = osc_count capped at 512 oscillators, then four passes
//  through the serial multiplier.
//  one item is worked at a time; the input is ready only when the block is idle.
//  a stalled output holds its item; the next item is taken meanwhile but its
//  result waits for the output register to free up.
//  reset is synchronous; the phase store itself is not cleared.
`include "assert_macros.svh"

module nonlocal_phase_oscillator_update
    import nops_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [8:0] index, [24:9] phase_in
    input  logic [0:0]           s_axis_tuser,   // [0] op
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [8:0] index_out, [24:9] phase_out
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PJ_RD  = 3'd1;
    localparam logic [2:0] ST_PJ_LD  = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_MSTART = 3'd4;
    localparam logic [2:0] ST_MWAIT  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // multiply passes after the sweep
    localparam logic [1:0] MSTEP_INV = 2'd0;
    localparam logic [1:0] MSTEP_TC  = 2'd1;
    localparam logic [1:0] MSTEP_DT  = 2'd2;
    localparam logic [1:0] MSTEP_K   = 2'd3;

    // configuration registers
    logic signed [15:0]     r_omega;
    logic [15:0]            r_time_const;
    logic [15:0]            r_step_dt;
    logic signed [15:0]     r_gain_a;
    logic [15:0]            r_phase_lag;
    logic [CNT_REG_W-1:0]   r_osc_count;
    logic [15:0]            r_inv_count;

    // control
    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [1:0]             r_mstep;
    logic [3:0]             r_pv;
    logic                   r_out_valid;

    // datapath
    logic [IDX_W-1:0]       r_idx;
    logic [PH_W-1:0]        r_phase;
    logic [PH_W-1:0]        r_pj;
    logic [CNT_W-1:0]       r_z;
    logic [PH_W-1:0]        r_rd;
    logic [15:0]            r_ka;
    logic signed [15:0]     r_ck;
    logic signed [15:0]     r_cc1;
    logic signed [15:0]     r_cc2;
    logic signed [31:0]     r_gk;
    logic signed [47:0]     r_term;
    logic signed [SUM_W-1:0] r_sum;
    logic [MUL_AW-1:0]      r_opa;
    logic [TDATA_W-1:0]     r_out_data;

    logic [PH_W-1:0]        r_phase_mem [0:MAX_OSC-1];

    logic                   w_in_acc;
    logic                   w_out_free;
    logic [CNT_W-1:0]       w_n;
    logic                   w_issue;
    logic [IDX_W-1:0]       w_zi;
    logic [IDX_W-1:0]       w_dist;
    logic [IDX_W+15:0]      w_kprod;
    logic [PH_W-1:0]        w_cd;
    logic signed [31:0]     w_kern;
    logic signed [41:0]     w_s28;
    logic [MUL_AW-1:0]      w_tcoup;
    logic signed [29:0]     w_coup;
    logic signed [MUL_AW-1:0] w_f;
    logic [MUL_AW-1:0]      w_round;
    logic [OSC_AW-1:0]      w_raddr;
    logic                   w_we;
    logic [MUL_BW-1:0]      w_mul_b;
    t_mul_req               w_mul_req;
    t_mul_rsp               w_mul_rsp;

    // handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega      <= RST_OMEGA;
            r_time_const <= RST_TIME_CONST;
            r_step_dt    <= RST_STEP_DT;
            r_gain_a     <= RST_GAIN_A;
            r_phase_lag  <= RST_PHASE_LAG;
            r_osc_count  <= RST_OSC_COUNT;
            r_inv_count  <= RST_INV_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OMEGA:      r_omega      <= i_cfg_data;
                CFG_TIME_CONST: r_time_const <= i_cfg_data;
                CFG_STEP_DT:    r_step_dt    <= i_cfg_data;
                CFG_GAIN_A:     r_gain_a     <= i_cfg_data;
                CFG_PHASE_LAG:  r_phase_lag  <= i_cfg_data;
                CFG_OSC_COUNT:  r_osc_count  <= i_cfg_data[CNT_REG_W-1:0];
                CFG_INV_COUNT:  r_inv_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ring size capped at the store depth
    assign w_n = (32'(r_osc_count) > 32'(MAX_OSC)) ? CNT_W'(MAX_OSC) : CNT_W'(r_osc_count);

    // sweep issue and kernel angle
    assign w_issue = (r_state == ST_SWEEP) && (r_z < w_n);
    assign w_zi    = IDX_W'(r_z);
    assign w_dist  = (r_idx > w_zi) ? (r_idx - w_zi) : (w_zi - r_idx);
    assign w_kprod = (IDX_W+16)'(w_dist) * (IDX_W+16)'(r_inv_count);

    // phase difference for the coupling cosine
    assign w_cd   = r_pj - r_rd - r_phase_lag;
    assign w_kern = r_gk + KERN_ONE;

    // coupling and phase increment
    assign w_s28   = r_sum[SUM_W-1:14];
    assign w_tcoup = w_mul_rsp.prod + (MUL_AW'(1) << 33);
    assign w_coup  = $signed(w_tcoup[63:34]);
    assign w_f     = MUL_AW'(r_omega) - MUL_AW'(w_coup);
    assign w_round = w_mul_rsp.prod + (MUL_AW'(1) << 47);

    // phase store ports
    assign w_raddr = (r_state == ST_SWEEP) ? r_z[OSC_AW-1:0] : OSC_AW'(r_idx);
    assign w_we    = (r_state == ST_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_phase_mem[OSC_AW'(r_idx)] <= r_phase;
        end
        r_rd <= r_phase_mem[w_raddr];
    end

    // multiplier operand select
    always_comb begin
        case (r_mstep)
            MSTEP_INV: w_mul_b = MUL_BW'(r_inv_count);
            MSTEP_TC:  w_mul_b = MUL_BW'(r_time_const);
            MSTEP_DT:  w_mul_b = MUL_BW'(r_step_dt);
            MSTEP_K:   w_mul_b = KTURN_Q14;
            default:   w_mul_b = '0;
        endcase
    end

    assign w_mul_req.valid = (r_state == ST_MSTART);
    assign w_mul_req.a     = r_opa;
    assign w_mul_req.b     = w_mul_b;

    nops_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (s_axis_tuser[0] == OP_LOAD) ? ST_DONE : ST_PJ_RD;
                end
            end
            ST_PJ_RD:  n_state = ST_PJ_LD;
            ST_PJ_LD:  n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (!w_issue && (r_pv == '0)) begin
                    n_state = ST_MSTART;
                end
            end
            ST_MSTART: n_state = ST_MWAIT;
            ST_MWAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = (r_mstep == MSTEP_K) ? ST_DONE : ST_MSTART;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mstep     <= MSTEP_INV;
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= {r_pv[2:0], w_issue};
            if (r_state == ST_SWEEP) begin
                r_mstep <= MSTEP_INV;
            end else if ((r_state == ST_MWAIT) && w_mul_rsp.done) begin
                r_mstep <= r_mstep + 1'b1;
            end
            if (w_we) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, sweep pipeline and result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_idx   <= s_axis_tdata[IDX_W-1:0];
            r_phase <= s_axis_tdata[IDX_W+PH_W-1:IDX_W];
            r_z     <= '0;
            r_sum   <= '0;
        end else begin
            if (w_issue) begin
                r_z <= r_z + 1'b1;
            end
            if (r_pv[3]) begin
                r_sum <= r_sum + SUM_W'(r_term);
            end
        end
        if (r_state == ST_PJ_LD) begin
            r_pj <= r_rd;
        end
        // stage 0: kernel angle
        r_ka   <= w_kprod[15:0];
        // stage 1: both cosines
        r_ck   <= cos_lookup(r_ka);
        r_cc1  <= cos_lookup(w_cd);
        // stage 2: kernel modulation
        r_gk   <= r_gain_a * r_ck;
        r_cc2  <= r_cc1;
        // stage 3: weighted term
        r_term <= w_kern * r_cc2;
        // multiply chain operands
        if ((r_state == ST_SWEEP) && (n_state == ST_MSTART)) begin
            r_opa <= MUL_AW'(w_s28);
        end else if ((r_state == ST_MWAIT) && w_mul_rsp.done) begin
            case (r_mstep)
                MSTEP_INV: r_opa <= w_f;
                MSTEP_TC:  r_opa <= w_mul_rsp.prod;
                MSTEP_DT:  r_opa <= w_mul_rsp.prod;
                MSTEP_K:   r_phase <= r_pj + w_round[63:48];
                default: ;
            endcase
        end
        if (w_we) begin
            r_out_data <= TDATA_W'({r_phase, r_idx});
        end
    end

    // checks
    `ASSERT_CLK(a_sweep_bound, i_clk, i_rst_n, (r_state == ST_SWEEP) |-> (r_z <= w_n),
                "sweep index ran past the ring size")
    `ASSERT_CLK(a_sweep_drained, i_clk, i_rst_n,
                ((r_state == ST_SWEEP) && (n_state != ST_SWEEP)) |-> (r_pv == '0),
                "sweep left with terms still in flight")
    `ASSERT_CLK(a_mul_done_wait, i_clk, i_rst_n, w_mul_rsp.done |-> (r_state == ST_MWAIT),
                "multiplier result arrived outside the wait state")

endmodule
